// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define CHK_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// Clocked property, checked during reset as well.
`define CHK_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) (prop)) \
      else $error("%m: assertion failed");

`endif

// ===== rtl/ntpcal_pkg.sv =====
// ----------------------------------------------------------------------------
// ntpcal_pkg
// Types, constants and tables for the NTP seconds to calendar date converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ntpcal_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADJUST,
      ST_ERA,
      ST_YEAR,
      ST_MONTH,
      ST_DAY,
      ST_HOUR,
      ST_MINUTE,
      ST_FINISH
   } state_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_TZ_NEGATIVE = 2'd0;
   localparam logic [1:0] CSR_TZ_HOURS    = 2'd1;
   localparam logic [1:0] CSR_TZ_MINUTES  = 2'd2;

   localparam logic [1:0] LI_UNSYNC = 2'd3;

   localparam logic [31:0] SECS_MINUTE          = 32'd60;
   localparam logic [31:0] SECS_HOUR            = 32'd3600;
   localparam logic [31:0] SECS_DAY             = 32'd86400;
   localparam logic [31:0] SECS_YEAR            = 32'd31536000;
   localparam logic [31:0] SECS_LEAP_YEAR       = 32'd31622400;
   localparam logic [31:0] SECS_ERA_2010_START  = 32'd3471292800;
   localparam logic [31:0] SECS_2036_OFFSET     = 32'd3220096;

   localparam logic [15:0] OFF_SECS_HOUR   = 16'd3600;
   localparam logic [15:0] OFF_SECS_MINUTE = 16'd60;

   localparam logic [11:0] BASE_YEAR_HIGH  = 12'd2036;
   localparam logic [11:0] BASE_YEAR_LOW   = 12'd2010;
   localparam logic [11:0] YEAR_CENTURY    = 12'd2100;

   localparam logic [3:0] MONTH_FIRST = 4'd1;
   localparam logic [3:0] MONTH_LAST  = 4'd12;

   // Length of a month in seconds
   function automatic logic [21:0] month_secs(input logic [3:0] month, input logic leap);
      logic [21:0] secs;
      unique case (month)
         4'd2:    secs = leap ? 22'd2505600 : 22'd2419200;
         4'd4,
         4'd6,
         4'd9,
         4'd11:   secs = 22'd2592000;
         default: secs = 22'd2678400;
      endcase
      return secs;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ntp_seconds_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// ntp_seconds_to_calendar_date
// Adjusts for the time zone, picks the era, then counts off years, months,
// days, hours and minutes; an unsynchronized beat skips the counting. All
// counting goes through one shared 32-bit subtract/compare unit. One timestamp
// is converted at a time, and a result held by rsp_stall delays the next;
// req_stall is high while a conversion runs. Reset (synchronous) clears the
// time-zone registers to zero and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ntp_seconds_to_calendar_date
   import ntpcal_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [5:0]  csr_wdata,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_ntp_seconds,
   input  wire logic [1:0]  req_leap_indicator,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_cal_year,
   output logic [3:0]       rsp_cal_month,
   output logic [4:0]       rsp_cal_day,
   output logic [4:0]       rsp_cal_hour,
   output logic [5:0]       rsp_cal_minute,
   output logic [5:0]       rsp_cal_second,
   output logic             rsp_unsynchronized,
   output logic             rsp_out_of_range
);

   state_type   state_ff, state_in;

   logic        tz_negative_ff;
   logic [3:0]  tz_hours_ff;
   logic [5:0]  tz_minutes_ff;

   logic [31:0] s_ff, s_in;
   logic [15:0] off_ff, off_in;
   logic        unsync_ff, unsync_in;
   logic        oor_ff, oor_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] out_year_ff, out_year_in;
   logic [3:0]  out_month_ff, out_month_in;
   logic [4:0]  out_day_ff, out_day_in;
   logic [4:0]  out_hour_ff, out_hour_in;
   logic [5:0]  out_minute_ff, out_minute_in;
   logic [5:0]  out_second_ff, out_second_in;
   logic        out_unsync_ff, out_unsync_in;
   logic        out_oor_ff, out_oor_in;

   logic        leap;
   logic [31:0] operand;
   logic [32:0] diff;
   logic        borrow;
   logic        out_free;

   assign csr_ready = 1'b1;

   // Gregorian rule over 2010..2104: only 2100 is a skipped century
   assign leap = (year_ff[1:0] == 2'b00) && (year_ff != YEAR_CENTURY);

   // Shared subtract/compare unit
   always_comb begin
      case (state_ff)
         ST_ERA:    operand = SECS_ERA_2010_START;
         ST_YEAR:   operand = leap ? SECS_LEAP_YEAR : SECS_YEAR;
         ST_MONTH:  operand = 32'(month_secs(month_ff, leap));
         ST_DAY:    operand = SECS_DAY;
         ST_HOUR:   operand = SECS_HOUR;
         ST_MINUTE: operand = SECS_MINUTE;
         default:   operand = '0;
      endcase
   end

   assign diff     = {1'b0, s_ff} - {1'b0, operand};
   assign borrow   = diff[32];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_ADJUST;
         ST_ADJUST: state_in = unsync_ff ? ST_FINISH : ST_ERA;
         ST_ERA:    state_in = ST_YEAR;
         ST_YEAR:   if (borrow) state_in = ST_MONTH;
         ST_MONTH:  if (borrow || month_ff == MONTH_LAST) state_in = ST_DAY;
         ST_DAY:    if (borrow) state_in = ST_HOUR;
         ST_HOUR:   if (borrow) state_in = ST_MINUTE;
         ST_MINUTE: if (borrow) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs and datapath
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      s_in          = s_ff;
      off_in        = off_ff;
      unsync_in     = unsync_ff;
      oor_in        = oor_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_year_in   = out_year_ff;
      out_month_in  = out_month_ff;
      out_day_in    = out_day_ff;
      out_hour_in   = out_hour_ff;
      out_minute_in = out_minute_ff;
      out_second_in = out_second_ff;
      out_unsync_in = out_unsync_ff;
      out_oor_in    = out_oor_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               s_in      = req_ntp_seconds;
               unsync_in = (req_leap_indicator == LI_UNSYNC);
               off_in    = 16'(tz_hours_ff) * OFF_SECS_HOUR
                         + 16'(tz_minutes_ff) * OFF_SECS_MINUTE;
            end
         end
         ST_ADJUST: begin
            s_in      = tz_negative_ff ? s_ff - 32'(off_ff) : s_ff + 32'(off_ff);
            oor_in    = 1'b0;
            month_in  = MONTH_FIRST;
            day_in    = 5'd1;
            hour_in   = '0;
            minute_in = '0;
         end
         ST_ERA: begin
            if (!s_ff[31]) begin
               year_in = BASE_YEAR_HIGH;
               s_in    = s_ff + SECS_2036_OFFSET;
            end else begin
               year_in = BASE_YEAR_LOW;
               // before 2010: saturate to the start of the era
               if (borrow) begin
                  oor_in = 1'b1;
                  s_in   = '0;
               end else begin
                  s_in = diff[31:0];
               end
            end
         end
         ST_YEAR: begin
            if (!borrow) begin
               s_in    = diff[31:0];
               year_in = year_ff + 12'd1;
            end
         end
         ST_MONTH: begin
            if (!borrow && month_ff != MONTH_LAST) begin
               s_in     = diff[31:0];
               month_in = month_ff + 4'd1;
            end
         end
         ST_DAY: begin
            if (!borrow) begin
               s_in   = diff[31:0];
               day_in = day_ff + 5'd1;
            end
         end
         ST_HOUR: begin
            if (!borrow) begin
               s_in    = diff[31:0];
               hour_in = hour_ff + 5'd1;
            end
         end
         ST_MINUTE: begin
            if (!borrow) begin
               s_in      = diff[31:0];
               minute_in = minute_ff + 6'd1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_unsync_in = unsync_ff;
               if (unsync_ff) begin
                  out_year_in   = '0;
                  out_month_in  = '0;
                  out_day_in    = '0;
                  out_hour_in   = '0;
                  out_minute_in = '0;
                  out_second_in = '0;
                  out_oor_in    = 1'b0;
               end else begin
                  out_year_in   = year_ff;
                  out_month_in  = month_ff;
                  out_day_in    = day_ff;
                  out_hour_in   = hour_ff;
                  out_minute_in = minute_ff;
                  out_second_in = s_ff[5:0];
                  out_oor_in    = oor_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         tz_negative_ff <= 1'b0;
         tz_hours_ff    <= '0;
         tz_minutes_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TZ_NEGATIVE: tz_negative_ff <= csr_wdata[0];
               CSR_TZ_HOURS:    tz_hours_ff    <= csr_wdata[3:0];
               CSR_TZ_MINUTES:  tz_minutes_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff          <= s_in;
      off_ff        <= off_in;
      unsync_ff     <= unsync_in;
      oor_ff        <= oor_in;
      year_ff       <= year_in;
      month_ff      <= month_in;
      day_ff        <= day_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      out_year_ff   <= out_year_in;
      out_month_ff  <= out_month_in;
      out_day_ff    <= out_day_in;
      out_hour_ff   <= out_hour_in;
      out_minute_ff <= out_minute_in;
      out_second_ff <= out_second_in;
      out_unsync_ff <= out_unsync_in;
      out_oor_ff    <= out_oor_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cal_year       = out_year_ff;
   assign rsp_cal_month      = out_month_ff;
   assign rsp_cal_day        = out_day_ff;
   assign rsp_cal_hour       = out_hour_ff;
   assign rsp_cal_minute     = out_minute_ff;
   assign rsp_cal_second     = out_second_ff;
   assign rsp_unsynchronized = out_unsync_ff;
   assign rsp_out_of_range   = out_oor_ff;

endmodule

`default_nettype wire

// ===== rtl/ntpcal_checker.sv =====
// ----------------------------------------------------------------------------
// ntpcal_checker
// Port-level checks on the NTP seconds to calendar date converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ntpcal_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [11:0] rsp_cal_year,
   input wire logic [3:0]  rsp_cal_month,
   input wire logic [4:0]  rsp_cal_day,
   input wire logic [4:0]  rsp_cal_hour,
   input wire logic [5:0]  rsp_cal_minute,
   input wire logic [5:0]  rsp_cal_second,
   input wire logic        rsp_unsynchronized,
   input wire logic        rsp_out_of_range
);

   // an accepted beat closes the input while its conversion runs
   `CHK_ASSERT(a_busy_after_accept, clock, reset, (req_valid && !req_stall) |=> req_stall)

   `CHK_ASSERT(a_rsp_holds, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_cal_year) && $stable(rsp_cal_second)))

   `CHK_ASSERT(a_unsync_zero, clock, reset, (rsp_valid && rsp_unsynchronized) |-> (rsp_cal_year == 12'd0 && rsp_cal_month == 4'd0 && rsp_cal_day == 5'd0 && !rsp_out_of_range))

   `CHK_ASSERT(a_date_range, clock, reset, (rsp_valid && !rsp_unsynchronized) |-> (rsp_cal_year >= 12'd2010 && rsp_cal_year <= 12'd2104 && rsp_cal_month >= 4'd1 && rsp_cal_month <= 4'd12 && rsp_cal_day >= 5'd1))

   `CHK_ASSERT_ALWAYS(a_time_range, clock, (rsp_valid && !rsp_unsynchronized) |-> (rsp_cal_hour <= 5'd23 && rsp_cal_minute <= 6'd59 && rsp_cal_second <= 6'd59))

endmodule

bind ntp_seconds_to_calendar_date ntpcal_checker u_ntpcal_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_cal_year       (rsp_cal_year),
   .rsp_cal_month      (rsp_cal_month),
   .rsp_cal_day        (rsp_cal_day),
   .rsp_cal_hour       (rsp_cal_hour),
   .rsp_cal_minute     (rsp_cal_minute),
   .rsp_cal_second     (rsp_cal_second),
   .rsp_unsynchronized (rsp_unsynchronized),
   .rsp_out_of_range   (rsp_out_of_range)
);

`default_nettype wire
